// ===== design/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg
// Types and constants shared by the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

   localparam int TIME_W = 48;
   localparam int TAG_W  = 32;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // most timers popped by one check
   localparam int MAX_POPS = 8;

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;

   localparam logic [2:0] ST_CREATED   = 3'd0;
   localparam logic [2:0] ST_REMOVED   = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_EXPIRED   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CR_START,
      S_CR_RDORD,
      S_CR_RDSLOT,
      S_CR_CMP,
      S_CR_PLACE,
      S_RM_START,
      S_RM_RDORD,
      S_RM_STEP,
      S_RM_END,
      S_CK_HEAD,
      S_CK_RDSLOT,
      S_CK_CMP,
      S_CK_SHRD,
      S_CK_SHWR,
      S_CK_FINAL
   } sdtq_state_type;

   // per-cycle command to the slot store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_valid;
   } sdtq_slot_cmd_type;

endpackage

// ===== design/sdtq_slot_store.sv =====
// ----------------------------------------------------------------------------
// sdtq_slot_store
// Per-slot timer data memory with valid bits and lowest-free-slot search.
// ----------------------------------------------------------------------------
module sdtq_slot_store
   import sdtq_pkg::*;
#(
   parameter int DEPTH = 8,
   localparam int SW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  sdtq_slot_cmd_type cmd,
   input  logic [SW-1:0]     rd_addr,
   input  logic [SW-1:0]     wr_addr,
   input  logic [SW-1:0]     clr_addr,
   input  logic [TIME_W-1:0] wr_deadline,
   input  logic [TAG_W-1:0]  wr_tag,
   input  logic              wr_wakes,
   output logic [TIME_W-1:0] rd_deadline,
   output logic [TAG_W-1:0]  rd_tag,
   output logic              rd_wakes,
   output logic [DEPTH-1:0]  valid,
   output logic              free_found,
   output logic [SW-1:0]     free_slot
);

   logic [TIME_W-1:0] deadline_mem [DEPTH];
   logic [TAG_W-1:0]  tag_mem      [DEPTH];
   logic              wakes_mem    [DEPTH];

   logic [TIME_W-1:0] rd_deadline_ff;
   logic [TAG_W-1:0]  rd_tag_ff;
   logic              rd_wakes_ff;

   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         deadline_mem[wr_addr] <= wr_deadline;
         tag_mem[wr_addr]      <= wr_tag;
         wakes_mem[wr_addr]    <= wr_wakes;
      end
      if (cmd.rd_en) begin
         rd_deadline_ff <= deadline_mem[rd_addr];
         rd_tag_ff      <= tag_mem[rd_addr];
         rd_wakes_ff    <= wakes_mem[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (cmd.clr_valid) begin
         valid_in[clr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // lowest free slot wins
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SW'(i);
         end
      end
   end

   assign rd_deadline = rd_deadline_ff;
   assign rd_tag      = rd_tag_ff;
   assign rd_wakes    = rd_wakes_ff;
   assign valid       = valid_ff;

endmodule

// ===== design/sdtq_order_mem.sv =====
// ----------------------------------------------------------------------------
// sdtq_order_mem
// Sorted list of slot numbers, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sdtq_order_mem
   import sdtq_pkg::*;
#(
   parameter int DEPTH = 8,
   localparam int SW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [SW-1:0] wr_addr,
   input  logic [SW-1:0] wr_data,
   input  logic [SW-1:0] rd_addr,
   output logic [SW-1:0] rd_data
);

   logic [SW-1:0] order_mem [DEPTH];
   logic [SW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         order_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= order_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sorted_deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Pending timers kept in deadline order: create, remove and expiry check.
// ----------------------------------------------------------------------------
// Requests transfer on req_* when req_valid is high and req_stall is low;
// results transfer on rsp_* the same way with rsp_stall from the receiver.
// One request is worked at a time. Timer data lives in a slot memory, the
// deadline order in a position memory, both with registered reads; the walk
// over the sorted list makes one memory read per step:
//   create: a full queue is answered with ST_FULL without a walk; otherwise
//           the walk starts at the tail and shifts each timer later than
//           the new deadline up one position, stopping at the first that is not later or at the head
//   remove: walks the whole list and closes the gap; a bad handle gets ST_NOT_FOUND without a walk
//   check : pops due timers from the head, shifting the rest down after each,
//           until the list is empty, eight were popped or the head is not due
// The final result enters the output register on the edge that drops
// req_stall; the next request can transfer in the cycle after. Each result
// waits in the output register while rsp_stall is high; the sequencer waits
// only when it has a further result to load. Reset clears all valid bits,
// the pending count, the sequencer and rsp_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue
   import sdtq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [TIME_W-1:0] req_now_time,
   input  logic [31:0]       req_delta,
   input  logic              req_wake_thread,
   input  logic [TAG_W-1:0]  req_tag,
   input  logic [2:0]        req_handle,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [2:0]        rsp_slot,
   output logic [TAG_W-1:0]  rsp_expired_tag,
   output logic              rsp_expired_wakes_thread,
   output logic [TIME_W-1:0] rsp_deadline,
   output logic              rsp_last
);

   localparam int SW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [6:0] DEPTH_V = 7'(DEPTH);

   sdtq_state_type state_ff, state_in;

   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] dl_ff, dl_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              wake_ff, wake_in;
   logic [2:0]        handle_ff, handle_in;
   logic [SW-1:0]     new_slot_ff, new_slot_in;
   logic [SW-1:0]     prev_ff, prev_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              found_ff, found_in;
   logic [3:0]        pops_ff, pops_in;
   logic              held_valid_ff, held_valid_in;
   logic [2:0]        held_status_ff, held_status_in;
   logic [2:0]        held_slot_ff, held_slot_in;
   logic [TAG_W-1:0]  held_tag_ff, held_tag_in;
   logic              held_wakes_ff, held_wakes_in;
   logic [TIME_W-1:0] held_deadline_ff, held_deadline_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff;
   logic [2:0]        rsp_slot_ff;
   logic [TAG_W-1:0]  rsp_tag_ff;
   logic              rsp_wakes_ff;
   logic [TIME_W-1:0] rsp_deadline_ff;
   logic              rsp_last_ff;

   logic              out_load;
   logic              out_last;

   sdtq_slot_cmd_type slot_cmd;
   logic [SW-1:0]     slot_rd_addr;
   logic [SW-1:0]     slot_clr_addr;
   logic [TIME_W-1:0] slot_rd_deadline;
   logic [TAG_W-1:0]  slot_rd_tag;
   logic              slot_rd_wakes;
   logic [DEPTH-1:0]  slot_valid;
   logic              free_found;
   logic [SW-1:0]     free_slot;

   logic              order_wr_en;
   logic [SW-1:0]     order_wr_addr;
   logic [SW-1:0]     order_wr_data;
   logic [SW-1:0]     order_rd_addr;
   logic [SW-1:0]     order_rd_data;

   logic              req_accept;
   logic              out_free;
   logic [49:0]       sum;
   logic [TIME_W-1:0] sat_dl;
   logic [SW-1:0]     h_idx;
   logic              handle_ok;
   logic [CW-1:0]     idx_m1;
   logic [CW-1:0]     idx_p1;
   logic              due;
   logic              later;
   logic              pops_done;

   sdtq_slot_store #(.DEPTH(DEPTH)) u_slot_store (
      .clock       (clock),
      .reset       (reset),
      .cmd         (slot_cmd),
      .rd_addr     (slot_rd_addr),
      .wr_addr     (new_slot_ff),
      .clr_addr    (slot_clr_addr),
      .wr_deadline (dl_ff),
      .wr_tag      (tag_ff),
      .wr_wakes    (wake_ff),
      .rd_deadline (slot_rd_deadline),
      .rd_tag      (slot_rd_tag),
      .rd_wakes    (slot_rd_wakes),
      .valid       (slot_valid),
      .free_found  (free_found),
      .free_slot   (free_slot)
   );

   sdtq_order_mem #(.DEPTH(DEPTH)) u_order_mem (
      .clock   (clock),
      .wr_en   (order_wr_en),
      .wr_addr (order_wr_addr),
      .wr_data (order_wr_data),
      .rd_addr (order_rd_addr),
      .rd_data (order_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // now + delta, saturated into the time range
   assign sum = $signed({2'b00, req_now_time}) + $signed({{18{req_delta[31]}}, req_delta});
   always_comb begin
      if (sum[49]) begin
         sat_dl = '0;
      end else if (sum[48]) begin
         sat_dl = TIME_MAX;
      end else begin
         sat_dl = sum[TIME_W-1:0];
      end
   end

   assign h_idx     = SW'(handle_ff);
   assign handle_ok = ({4'b0000, handle_ff} < DEPTH_V) && slot_valid[h_idx];
   assign idx_m1    = idx_ff - CW'(1);
   assign idx_p1    = idx_ff + CW'(1);
   assign due       = slot_rd_deadline < now_ff;
   assign later     = slot_rd_deadline > dl_ff;
   assign pops_done = (pops_ff == 4'(MAX_POPS));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  OP_CREATE: state_in = S_CR_START;
                  OP_REMOVE: state_in = S_RM_START;
                  OP_CHECK:  state_in = S_CK_HEAD;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_CR_START: begin
            if (!free_found) begin
               state_in = S_CK_FINAL;
            end else if (count_ff == '0) begin
               state_in = S_CR_PLACE;
            end else begin
               state_in = S_CR_RDORD;
            end
         end
         S_CR_RDORD:  state_in = S_CR_RDSLOT;
         S_CR_RDSLOT: state_in = S_CR_CMP;
         S_CR_CMP: begin
            if (later && (idx_ff != CW'(1))) begin
               state_in = S_CR_RDORD;
            end else begin
               state_in = S_CR_PLACE;
            end
         end
         S_CR_PLACE: state_in = S_CK_FINAL;
         S_RM_START: begin
            if (!handle_ok) begin
               state_in = S_CK_FINAL;
            end else begin
               state_in = S_RM_RDORD;
            end
         end
         S_RM_RDORD: state_in = S_RM_STEP;
         S_RM_STEP: begin
            if (idx_p1 == count_ff) begin
               state_in = S_RM_END;
            end else begin
               state_in = S_RM_RDORD;
            end
         end
         S_RM_END: state_in = S_CK_FINAL;
         S_CK_HEAD: begin
            if ((count_ff == '0) || pops_done) begin
               state_in = S_CK_FINAL;
            end else begin
               state_in = S_CK_RDSLOT;
            end
         end
         S_CK_RDSLOT: state_in = S_CK_CMP;
         S_CK_CMP: begin
            if (!due) begin
               state_in = S_CK_FINAL;
            end else if (held_valid_ff && !out_free) begin
               state_in = S_CK_CMP;
            end else begin
               state_in = S_CK_SHRD;
            end
         end
         S_CK_SHRD: begin
            if (idx_ff > count_ff) begin
               state_in = S_CK_HEAD;
            end else begin
               state_in = S_CK_SHWR;
            end
         end
         S_CK_SHWR: state_in = S_CK_SHRD;
         S_CK_FINAL: begin
            // holds the final result until the output register is free
            if (!held_valid_ff || out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory commands
   always_comb begin
      now_in           = now_ff;
      dl_in            = dl_ff;
      tag_in           = tag_ff;
      wake_in          = wake_ff;
      handle_in        = handle_ff;
      new_slot_in      = new_slot_ff;
      prev_in          = prev_ff;
      idx_in           = idx_ff;
      count_in         = count_ff;
      found_in         = found_ff;
      pops_in          = pops_ff;
      held_valid_in    = held_valid_ff;
      held_status_in   = held_status_ff;
      held_slot_in     = held_slot_ff;
      held_tag_in      = held_tag_ff;
      held_wakes_in    = held_wakes_ff;
      held_deadline_in = held_deadline_ff;
      slot_cmd         = '0;
      slot_rd_addr     = '0;
      slot_clr_addr    = '0;
      order_wr_en      = 1'b0;
      order_wr_addr    = '0;
      order_wr_data    = '0;
      order_rd_addr    = '0;
      out_load         = 1'b0;
      out_last         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               now_in        = req_now_time;
               dl_in         = sat_dl;
               tag_in        = req_tag;
               wake_in       = req_wake_thread;
               handle_in     = req_handle;
               pops_in       = '0;
               held_valid_in = 1'b0;
            end
         end
         S_CR_START: begin
            new_slot_in = free_slot;
            idx_in      = count_ff;
            if (!free_found) begin
               held_valid_in    = 1'b1;
               held_status_in   = ST_FULL;
               held_slot_in     = '0;
               held_tag_in      = '0;
               held_wakes_in    = 1'b0;
               held_deadline_in = dl_ff;
            end
         end
         S_CR_RDORD: begin
            order_rd_addr = idx_m1[SW-1:0];
         end
         S_CR_RDSLOT: begin
            slot_cmd.rd_en = 1'b1;
            slot_rd_addr   = order_rd_data;
            prev_in        = order_rd_data;
         end
         S_CR_CMP: begin
            if (later) begin
               order_wr_en   = 1'b1;
               order_wr_addr = idx_ff[SW-1:0];
               order_wr_data = prev_ff;
               idx_in        = idx_m1;
            end
         end
         S_CR_PLACE: begin
            order_wr_en      = 1'b1;
            order_wr_addr    = idx_ff[SW-1:0];
            order_wr_data    = new_slot_ff;
            slot_cmd.wr_en   = 1'b1;
            count_in         = count_ff + CW'(1);
            held_valid_in    = 1'b1;
            held_status_in   = ST_CREATED;
            held_slot_in     = 3'(new_slot_ff);
            held_tag_in      = '0;
            held_wakes_in    = 1'b0;
            held_deadline_in = dl_ff;
         end
         S_RM_START: begin
            slot_cmd.rd_en = 1'b1;
            slot_rd_addr   = h_idx;
            idx_in         = '0;
            found_in       = 1'b0;
            if (!handle_ok) begin
               held_valid_in    = 1'b1;
               held_status_in   = ST_NOT_FOUND;
               held_slot_in     = handle_ff;
               held_tag_in      = '0;
               held_wakes_in    = 1'b0;
               held_deadline_in = '0;
            end
         end
         S_RM_RDORD: begin
            order_rd_addr = idx_ff[SW-1:0];
         end
         S_RM_STEP: begin
            if (found_ff) begin
               order_wr_en   = 1'b1;
               order_wr_addr = idx_m1[SW-1:0];
               order_wr_data = order_rd_data;
            end
            if (order_rd_data == h_idx) begin
               found_in = 1'b1;
            end
            idx_in = idx_p1;
         end
         S_RM_END: begin
            slot_cmd.clr_valid = 1'b1;
            slot_clr_addr      = h_idx;
            count_in           = count_ff - CW'(1);
            held_valid_in      = 1'b1;
            held_status_in     = ST_REMOVED;
            held_slot_in       = handle_ff;
            held_tag_in        = '0;
            held_wakes_in      = 1'b0;
            held_deadline_in   = slot_rd_deadline;
         end
         S_CK_HEAD: begin
            order_rd_addr = '0;
         end
         S_CK_RDSLOT: begin
            slot_cmd.rd_en = 1'b1;
            slot_rd_addr   = order_rd_data;
            prev_in        = order_rd_data;
         end
         S_CK_CMP: begin
            if (due && (!held_valid_ff || out_free)) begin
               out_load           = held_valid_ff;
               out_last           = 1'b0;
               held_valid_in      = 1'b1;
               held_status_in     = ST_EXPIRED;
               held_slot_in       = 3'(prev_ff);
               held_tag_in        = slot_rd_tag;
               held_wakes_in      = slot_rd_wakes;
               held_deadline_in   = slot_rd_deadline;
               slot_cmd.clr_valid = 1'b1;
               slot_clr_addr      = prev_ff;
               count_in           = count_ff - CW'(1);
               pops_in            = pops_ff + 4'd1;
               idx_in             = CW'(1);
            end
         end
         S_CK_SHRD: begin
            order_rd_addr = idx_ff[SW-1:0];
         end
         S_CK_SHWR: begin
            order_wr_en   = 1'b1;
            order_wr_addr = idx_m1[SW-1:0];
            order_wr_data = order_rd_data;
            idx_in        = idx_p1;
         end
         S_CK_FINAL: begin
            if (held_valid_ff && out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               held_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pops_ff       <= '0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pops_ff       <= pops_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff           <= now_in;
      dl_ff            <= dl_in;
      tag_ff           <= tag_in;
      wake_ff          <= wake_in;
      handle_ff        <= handle_in;
      new_slot_ff      <= new_slot_in;
      prev_ff          <= prev_in;
      idx_ff           <= idx_in;
      held_status_ff   <= held_status_in;
      held_slot_ff     <= held_slot_in;
      held_tag_ff      <= held_tag_in;
      held_wakes_ff    <= held_wakes_in;
      held_deadline_ff <= held_deadline_in;
      if (out_load) begin
         rsp_status_ff   <= held_status_ff;
         rsp_slot_ff     <= held_slot_ff;
         rsp_tag_ff      <= held_tag_ff;
         rsp_wakes_ff    <= held_wakes_ff;
         rsp_deadline_ff <= held_deadline_ff;
         rsp_last_ff     <= out_last;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = rsp_status_ff;
   assign rsp_slot                 = rsp_slot_ff;
   assign rsp_expired_tag          = rsp_tag_ff;
   assign rsp_expired_wakes_thread = rsp_wakes_ff;
   assign rsp_deadline             = rsp_deadline_ff;
   assign rsp_last                 = rsp_last_ff;

endmodule
